/* design/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, result codes and symbol lookup shared by the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

   typedef logic [1:0] kind_type;
   typedef logic [6:0] sym_type;
   typedef logic [7:0] byte_type;

   localparam kind_type KIND_BYTE     = 2'd0;
   localparam kind_type KIND_ERR      = 2'd1;
   localparam kind_type KIND_END_OK   = 2'd2;
   localparam kind_type KIND_END_PART = 2'd3;

   localparam logic CMD_DECODE = 1'b0;
   localparam logic CMD_END    = 1'b1;

   localparam sym_type SYM_PAD     = 7'd64;
   localparam sym_type SYM_INVALID = 7'd127;

   localparam byte_type CHAR_UP_A = 8'h41;
   localparam byte_type CHAR_UP_Z = 8'h5A;
   localparam byte_type CHAR_LO_A = 8'h61;
   localparam byte_type CHAR_LO_Z = 8'h7A;
   localparam byte_type CHAR_D0   = 8'h30;
   localparam byte_type CHAR_D9   = 8'h39;
   localparam byte_type CHAR_PLUS = 8'h2B;
   localparam byte_type CHAR_SLSH = 8'h2F;
   localparam byte_type CHAR_EQ   = 8'h3D;
   localparam byte_type CHAR_SP   = 8'h20;
   localparam byte_type CHAR_TAB  = 8'h09;
   localparam byte_type CHAR_LF   = 8'h0A;
   localparam byte_type CHAR_CR   = 8'h0D;

   localparam sym_type SYM_LO_BASE = 7'd26;
   localparam sym_type SYM_D_BASE  = 7'd52;
   localparam sym_type SYM_PLUS    = 7'd62;
   localparam sym_type SYM_SLSH    = 7'd63;

   function automatic sym_type sym_of(input byte_type c);
      sym_type s;
      s = SYM_INVALID;
      case (c) inside
         [CHAR_UP_A:CHAR_UP_Z]: s = 7'(c - CHAR_UP_A);
         [CHAR_LO_A:CHAR_LO_Z]: s = 7'(c - CHAR_LO_A) + SYM_LO_BASE;
         [CHAR_D0:CHAR_D9]:     s = 7'(c - CHAR_D0) + SYM_D_BASE;
         CHAR_PLUS:             s = SYM_PLUS;
         CHAR_SLSH:             s = SYM_SLSH;
         CHAR_EQ:               s = SYM_PAD;
         default:               s = SYM_INVALID;
      endcase
      return s;
   endfunction

   function automatic logic is_space(input byte_type c);
      return (c == CHAR_SP) || (c == CHAR_TAB) || (c == CHAR_LF) || (c == CHAR_CR);
   endfunction

endpackage

/* design/b64d_if.sv */
// ----------------------------------------------------------------------------
// b64d_req_if / b64d_rsp_if
// Valid/ready channels for characters in and decoded results out.
// ----------------------------------------------------------------------------
interface b64d_req_if
   import b64d_pkg::*;
();
   logic     valid;
   logic     ready;
   logic     command;
   byte_type char_in;

   modport source (output valid, output command, output char_in, input ready);
   modport sink   (input valid, input command, input char_in, output ready);
endinterface

interface b64d_rsp_if
   import b64d_pkg::*;
();
   logic     valid;
   logic     ready;
   kind_type kind;
   byte_type byte_out;
   logic     last;

   modport source (output valid, output kind, output byte_out, output last, input ready);
   modport sink   (input valid, input kind, input byte_out, input last, output ready);
endinterface

/* design/base64_stream_decoder_top.sv */
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Strict streaming base64 decoder: one character in, zero to three results out.
// ----------------------------------------------------------------------------
// Each accepted item is decoded in the cycle it is taken and its results are
// loaded into a result register that holds up to three entries. While the
// receiver is ready, items that yield at most one result each move at one
// item per cycle. A group that releases more than one byte keeps req_chan
// ready low while the result register drains, until its last byte is taken.
// Errors are sticky until reset; the end command reports whether a group is
// open.
module base64_stream_decoder_top
   import b64d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   b64d_req_if.sink    req_chan,
   b64d_rsp_if.source  rsp_chan
);

   sym_type    store_ff [3];
   sym_type    store_in [3];
   logic [1:0] count_ff, count_in;
   logic       end_ff, end_in;
   logic       err_ff, err_in;

   logic [1:0] res_cnt_ff, res_cnt_in;
   kind_type   res_kind_ff, res_kind_in;
   byte_type   res_byte_ff [3];
   byte_type   res_byte_in [3];

   logic       acc, pop;
   sym_type    sym, v0, v1, v2, v3, v2z, v3z;
   logic [1:0] gen_cnt;
   kind_type   gen_kind;
   byte_type   gen_byte [3];
   logic       bad;

   assign pop            = rsp_chan.valid && rsp_chan.ready;
   assign rsp_chan.valid = (res_cnt_ff != 2'd0);
   assign rsp_chan.kind  = res_kind_ff;
   assign rsp_chan.byte_out = res_byte_ff[0];
   assign rsp_chan.last  = (res_cnt_ff == 2'd1);
   assign req_chan.ready = (res_cnt_ff == 2'd0) || ((res_cnt_ff == 2'd1) && rsp_chan.ready);
   assign acc            = req_chan.valid && req_chan.ready;

   assign sym = sym_of(req_chan.char_in);
   assign v0  = store_ff[0];
   assign v1  = store_ff[1];
   assign v2  = store_ff[2];
   assign v3  = sym;
   assign v2z = (v2 == SYM_PAD) ? 7'd0 : v2;
   assign v3z = (v3 == SYM_PAD) ? 7'd0 : v3;
   assign bad = (v0 == SYM_PAD) || (v1 == SYM_PAD)
             || ((v2 == SYM_PAD) && (v3 != SYM_PAD))
             || ((v2 == SYM_PAD) && (v1[3:0] != 4'd0))
             || ((v3 == SYM_PAD) && (v2[1:0] != 2'd0));

   always_comb begin
      store_in = store_ff;
      count_in = count_ff;
      end_in   = end_ff;
      err_in   = err_ff;
      gen_cnt  = 2'd0;
      gen_kind = KIND_BYTE;
      gen_byte[0] = '0;
      gen_byte[1] = '0;
      gen_byte[2] = '0;
      if (err_ff) begin
         gen_cnt  = 2'd1;
         gen_kind = KIND_ERR;
      end else if (req_chan.command == CMD_END) begin
         gen_cnt  = 2'd1;
         gen_kind = (count_ff == 2'd0) ? KIND_END_OK : KIND_END_PART;
      end else if (is_space(req_chan.char_in)) begin
         gen_cnt = 2'd0;
      end else if (end_ff || (sym == SYM_INVALID)) begin
         err_in   = 1'b1;
         count_in = 2'd0;
         gen_cnt  = 2'd1;
         gen_kind = KIND_ERR;
      end else if (count_ff != 2'd3) begin
         store_in[count_ff] = sym;
         count_in = count_ff + 2'd1;
      end else begin
         count_in = 2'd0;
         if (bad) begin
            err_in   = 1'b1;
            gen_cnt  = 2'd1;
            gen_kind = KIND_ERR;
         end else begin
            gen_byte[0] = {v0[5:0], v1[5:4]};
            gen_byte[1] = {v1[3:0], v2z[5:2]};
            gen_byte[2] = {v2z[1:0], v3z[5:0]};
            if (v2 == SYM_PAD) begin
               gen_cnt = 2'd1;
               end_in  = 1'b1;
            end else if (v3 == SYM_PAD) begin
               gen_cnt = 2'd2;
               end_in  = 1'b1;
            end else begin
               gen_cnt = 2'd3;
            end
         end
      end
   end

   always_comb begin
      res_cnt_in  = res_cnt_ff;
      res_kind_in = res_kind_ff;
      res_byte_in = res_byte_ff;
      if (acc) begin
         res_cnt_in  = gen_cnt;
         res_kind_in = gen_kind;
         res_byte_in = gen_byte;
      end else if (pop) begin
         res_cnt_in     = res_cnt_ff - 2'd1;
         res_byte_in[0] = res_byte_ff[1];
         res_byte_in[1] = res_byte_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= 2'd0;
         end_ff     <= 1'b0;
         err_ff     <= 1'b0;
         res_cnt_ff <= 2'd0;
         store_ff[0] <= '0;
         store_ff[1] <= '0;
         store_ff[2] <= '0;
      end else begin
         res_cnt_ff <= res_cnt_in;
         if (acc) begin
            count_ff <= count_in;
            end_ff   <= end_in;
            err_ff   <= err_in;
            store_ff <= store_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_kind_ff <= res_kind_in;
      res_byte_ff <= res_byte_in;
   end

endmodule

/* design/b64d_checker.sv */
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level properties of the base64 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module b64d_checker
   import b64d_pkg::*;
(
   input logic     clock,
   input logic     reset,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input kind_type rsp_kind,
   input byte_type rsp_byte_out,
   input logic     rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_ctrl_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_BYTE) |-> rsp_last)
      else $error("error or end result not marked last");

   a_ctrl_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_BYTE) |-> (rsp_byte_out == 8'd0))
      else $error("nonzero byte on error or end result");

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (rsp_kind == KIND_ERR)
      |=> !rsp_valid || (rsp_kind == KIND_ERR))
      else $error("non-error result after error");

endmodule

bind base64_stream_decoder_top b64d_checker u_b64d_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_kind     (rsp_chan.kind),
   .rsp_byte_out (rsp_chan.byte_out),
   .rsp_last     (rsp_chan.last)
);

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the base64 stream decoder. A driver feeds characters
// and end checks from a queue, a decode model predicts the results of every
// accepted item, and a monitor compares each result field by field. Sender
// gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module testbench
   import b64d_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_LINES   = 40;

   typedef struct packed {
      logic     command;
      byte_type char_in;
   } char_item_type;

   typedef struct packed {
      kind_type kind;
      byte_type byte_out;
      logic     last;
   } result_type;

   typedef enum int {
      TAIL_BAD_CHAR,
      TAIL_BAD_GROUP,
      TAIL_AFTER_END
   } tail_case_type;

   typedef enum int {
      GRP_PAD_FIRST,
      GRP_PAD_SECOND,
      GRP_PAD_THIRD_ONLY,
      GRP_ONE_BYTE_BITS,
      GRP_TWO_BYTE_BITS
   } bad_group_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   b64d_req_if req_link ();
   b64d_rsp_if rsp_link ();

   logic          req_valid = 1'b0;
   char_item_type bus_item  = '0;
   logic          rsp_ready = 1'b0;

   assign req_link.valid   = req_valid;
   assign req_link.command = bus_item.command;
   assign req_link.char_in = bus_item.char_in;
   assign rsp_link.ready   = rsp_ready;

   base64_stream_decoder_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_link),
      .rsp_chan (rsp_link)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   char_item_type pending_chars [$];
   result_type    expected_results [$];
   int            queued_count   = 0;
   int            accepted_count = 0;
   int            mismatch_count = 0;
   int            cycle_count    = 0;
   int            idle_pct       = 0;
   int            stall_pct      = 0;

   // decode model state
   sym_type    grp_syms [4];
   logic [1:0] grp_count;
   logic       past_pad;
   logic       sticky_err;

   task automatic log_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_LINES)
         $display("MISMATCH cycle %0d: %s", cycle_count, msg);
   endtask

   function automatic logic is_blank(input byte_type c);
      return c == CHAR_SP || c == CHAR_TAB || c == CHAR_LF || c == CHAR_CR;
   endfunction

   function automatic sym_type char_to_sym(input byte_type c);
      if (c >= CHAR_UP_A && c <= CHAR_UP_Z) return sym_type'(c - CHAR_UP_A);
      if (c >= CHAR_LO_A && c <= CHAR_LO_Z) return sym_type'(c - CHAR_LO_A + 26);
      if (c >= CHAR_D0 && c <= CHAR_D9) return sym_type'(c - CHAR_D0 + 52);
      if (c == CHAR_PLUS) return SYM_PLUS;
      if (c == CHAR_SLSH) return SYM_SLSH;
      if (c == CHAR_EQ) return SYM_PAD;
      return SYM_INVALID;
   endfunction

   function automatic byte_type sym_to_char(input sym_type s);
      if (s < 26) return byte_type'(CHAR_UP_A + s);
      if (s < 52) return byte_type'(CHAR_LO_A + s - 26);
      if (s < 62) return byte_type'(CHAR_D0 + s - 52);
      if (s == SYM_PLUS) return CHAR_PLUS;
      if (s == SYM_SLSH) return CHAR_SLSH;
      return CHAR_EQ;
   endfunction

   task automatic emit_result(input kind_type kind, input byte_type data, input logic last);
      expected_results.push_back('{kind: kind, byte_out: data, last: last});
   endtask

   task automatic raise_error();
      sticky_err = 1'b1;
      grp_count  = 2'd0;
      emit_result(KIND_ERR, 8'h00, 1'b1);
   endtask

   task automatic predict_decode(input char_item_type it);
      sym_type  s, v0, v1, v2, v3;
      int       n;
      byte_type b [3];
      if (sticky_err) begin
         emit_result(KIND_ERR, 8'h00, 1'b1);
         return;
      end
      if (it.command == CMD_END) begin
         emit_result(grp_count == 2'd0 ? KIND_END_OK : KIND_END_PART, 8'h00, 1'b1);
         return;
      end
      if (is_blank(it.char_in)) return;
      if (past_pad) begin
         raise_error();
         return;
      end
      s = char_to_sym(it.char_in);
      if (s == SYM_INVALID) begin
         raise_error();
         return;
      end
      grp_syms[grp_count] = s;
      if (grp_count != 2'd3) begin
         grp_count++;
         return;
      end
      grp_count = 2'd0;
      v0 = grp_syms[0];
      v1 = grp_syms[1];
      v2 = grp_syms[2];
      v3 = grp_syms[3];
      if (v0 == SYM_PAD || v1 == SYM_PAD || (v2 == SYM_PAD && v3 != SYM_PAD) ||
          (v2 == SYM_PAD && v1[3:0] != 4'd0) || (v3 == SYM_PAD && v2[1:0] != 2'd0)) begin
         raise_error();
         return;
      end
      n = (v2 == SYM_PAD) ? 1 : (v3 == SYM_PAD) ? 2 : 3;
      if (n != 3) past_pad = 1'b1;
      if (v2 == SYM_PAD) v2 = '0;
      if (v3 == SYM_PAD) v3 = '0;
      b[0] = {v0[5:0], v1[5:4]};
      b[1] = {v1[3:0], v2[5:2]};
      b[2] = {v2[1:0], v3[5:0]};
      for (int i = 0; i < n; i++)
         emit_result(KIND_BYTE, b[i], i == n - 1);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         grp_syms   = '{default: '0};
         grp_count  = 2'd0;
         past_pad   = 1'b0;
         sticky_err = 1'b0;
      end else begin
         if (req_valid && req_link.ready) begin
            predict_decode(bus_item);
            accepted_count++;
         end
         if (!req_valid || req_link.ready) begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= idle_pct) begin
               bus_item  <= pending_chars.pop_front();
               req_valid <= 1'b1;
            end else begin
               bus_item  <= '{command: 1'($urandom_range(1)), char_in: 8'($urandom_range(255))};
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_link.valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               log_mismatch($sformatf("unexpected result kind %0d byte %02h last %0b",
                                      rsp_link.kind, rsp_link.byte_out, rsp_link.last));
            end else begin
               result_type want;
               want = expected_results.pop_front();
               if (rsp_link.kind !== want.kind)
                  log_mismatch($sformatf("kind %0d, want %0d", rsp_link.kind, want.kind));
               if (rsp_link.byte_out !== want.byte_out)
                  log_mismatch($sformatf("byte_out %02h, want %02h",
                                         rsp_link.byte_out, want.byte_out));
               if (rsp_link.last !== want.last)
                  log_mismatch($sformatf("last %0b, want %0b", rsp_link.last, want.last));
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic push_item(input logic cmd, input byte_type ch);
      pending_chars.push_back('{command: cmd, char_in: ch});
      queued_count++;
   endtask

   task automatic push_text(input string text);
      for (int i = 0; i < text.len(); i++)
         push_item(CMD_DECODE, byte_type'(text[i]));
   endtask

   function automatic byte_type rand_blank();
      case ($urandom_range(3))
         0: return CHAR_SP;
         1: return CHAR_TAB;
         2: return CHAR_LF;
         default: return CHAR_CR;
      endcase
   endfunction

   function automatic sym_type rand_sym();
      return sym_type'($urandom_range(63));
   endfunction

   task automatic push_sym(input sym_type s);
      int r;
      r = $urandom_range(99);
      if (r < 12)
         push_item(CMD_DECODE, rand_blank());
      else if (r < 18)
         push_item(CMD_END, 8'($urandom_range(255)));
      push_item(CMD_DECODE, sym_to_char(s));
   endtask

   task automatic push_group(input sym_type s0, input sym_type s1,
                             input sym_type s2, input sym_type s3);
      push_sym(s0);
      push_sym(s1);
      push_sym(s2);
      push_sym(s3);
   endtask

   task automatic fill_groups(input int target);
      while (queued_count < target)
         push_group(rand_sym(), rand_sym(), rand_sym(), rand_sym());
   endtask

   task automatic wait_drained();
      while (accepted_count != queued_count) @(posedge clock);
   endtask

   task automatic push_bad_group();
      case (bad_group_type'($urandom_range(4)))
         GRP_PAD_FIRST:
            push_group(SYM_PAD, rand_sym(), rand_sym(), rand_sym());
         GRP_PAD_SECOND:
            push_group(rand_sym(), SYM_PAD, rand_sym(), rand_sym());
         GRP_PAD_THIRD_ONLY:
            push_group(rand_sym(), rand_sym(), SYM_PAD, rand_sym());
         GRP_ONE_BYTE_BITS:
            push_group(rand_sym(), (rand_sym() & 7'h30) | sym_type'($urandom_range(1, 15)),
                       SYM_PAD, SYM_PAD);
         default:
            push_group(rand_sym(), rand_sym(),
                       (rand_sym() & 7'h3C) | sym_type'($urandom_range(1, 3)), SYM_PAD);
      endcase
   endtask

   initial begin
      tail_case_type tail;
      byte_type      bad;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: end checks, whitespace, extremes of the alphabet
      push_item(CMD_END, 8'h00);
      push_item(CMD_DECODE, CHAR_SP);
      push_item(CMD_DECODE, CHAR_TAB);
      push_item(CMD_DECODE, CHAR_LF);
      push_item(CMD_DECODE, CHAR_CR);
      push_text("T");
      push_item(CMD_END, 8'hFF);
      push_text("W");
      push_item(CMD_END, 8'h00);
      push_text("Fu");
      push_text("AAAA");
      push_text("////");
      push_text("+/9z");
      push_text("aZ0A");

      idle_pct  <= 0;
      stall_pct <= 0;
      fill_groups(110);
      wait_drained();

      idle_pct  <= 78;
      stall_pct <= 0;
      fill_groups(190);
      wait_drained();

      idle_pct  <= 0;
      stall_pct <= 78;
      fill_groups(270);
      wait_drained();

      idle_pct  <= 17;
      stall_pct <= 17;
      fill_groups(310);
      tail = tail_case_type'($urandom_range(2));
      case (tail)
         TAIL_BAD_CHAR: begin
            repeat ($urandom_range(3)) push_sym(rand_sym());
            if ($urandom_range(3) == 0) begin
               bad = 8'h00;
            end else begin
               bad = 8'($urandom_range(255));
               while (char_to_sym(bad) != SYM_INVALID || is_blank(bad))
                  bad = 8'($urandom_range(255));
            end
            push_item(CMD_DECODE, bad);
         end
         TAIL_BAD_GROUP:
            push_bad_group();
         default: begin
            if ($urandom_range(1))
               push_group(rand_sym(), rand_sym() & 7'h30, SYM_PAD, SYM_PAD);
            else
               push_group(rand_sym(), rand_sym(), rand_sym() & 7'h3C, SYM_PAD);
            push_item(CMD_DECODE, rand_blank());
            push_item(CMD_END, 8'($urandom_range(255)));
            push_item(CMD_DECODE, sym_to_char(sym_type'($urandom_range(64))));
         end
      endcase
      // sticky error: everything after it reports an error
      repeat (30) begin
         push_item(1'($urandom_range(4) == 0), 8'($urandom_range(255)));
      end
      wait_drained();

      while (expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
